[hw/rtl/tmi_pkg.sv]
// Shared types, constants and helpers for the tape machine interpreter.
// Used by every module under hw/rtl; has no dependencies of its own.
package tmi_pkg;

	localparam int PROG_DEPTH = 4096;
	localparam int CELL_DEPTH = 32768;
	localparam int PROG_AW    = $clog2(PROG_DEPTH);
	localparam int CELL_AW    = $clog2(CELL_DEPTH);
	localparam int ADDR_W     = 12;
	localparam int DEPTH_W    = PROG_AW + 1;

	localparam logic [PROG_AW-1:0] PROG_LAST = PROG_AW'(PROG_DEPTH - 1);
	localparam logic [CELL_AW-1:0] CELL_LAST = CELL_AW'(CELL_DEPTH - 1);

	localparam logic [7:0] CH_END   = 8'h00;
	localparam logic [7:0] CH_RIGHT = 8'h3E;
	localparam logic [7:0] CH_LEFT  = 8'h3C;
	localparam logic [7:0] CH_INC   = 8'h2B;
	localparam logic [7:0] CH_DEC   = 8'h2D;
	localparam logic [7:0] CH_IN    = 8'h2C;
	localparam logic [7:0] CH_OUT   = 8'h2E;
	localparam logic [7:0] CH_OPEN  = 8'h5B;
	localparam logic [7:0] CH_CLOSE = 8'h5D;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_STEP = 1'b1;

	typedef enum logic [1:0] {
		HALT_RUN,
		HALT_DONE,
		HALT_BRACKET
	} halt_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic              req_type;
		logic [ADDR_W-1:0] prog_addr;
		logic [7:0]        prog_char;
		logic [7:0]        in_byte;
	} req_t;

	typedef struct packed {
		logic              out_valid;
		logic [7:0]        out_byte;
		logic              in_taken;
		logic [1:0]        run_status;
		logic [ADDR_W-1:0] next_ip;
	} rsp_t;

	typedef struct packed {
		logic               rd_en;
		logic [PROG_AW-1:0] rd_addr;
		logic               wr_en;
		logic [PROG_AW-1:0] wr_addr;
		logic [7:0]         wr_data;
	} prog_req_t;

	typedef struct packed {
		logic               rd_en;
		logic               wr_en;
		logic [CELL_AW-1:0] addr;
		logic [7:0]         wr_data;
	} cell_req_t;

	typedef struct packed {
		logic       init;
		logic [7:0] data;
	} cell_rd_t;

	function automatic logic [PROG_AW-1:0] prog_index(input logic [ADDR_W-1:0] a);
		logic [PROG_AW+ADDR_W-1:0] w;
		w = {{PROG_AW{1'b0}}, a};
		return w[PROG_AW-1:0];
	endfunction

	function automatic logic prog_in_range(input logic [ADDR_W-1:0] a);
		logic [PROG_AW+ADDR_W-1:0] w;
		w = {{PROG_AW{1'b0}}, a};
		return w < (PROG_AW + ADDR_W)'(PROG_DEPTH);
	endfunction

	function automatic logic [ADDR_W-1:0] ip_field(input logic [PROG_AW-1:0] ip);
		logic [PROG_AW+ADDR_W-1:0] w;
		w = {{ADDR_W{1'b0}}, ip};
		return w[ADDR_W-1:0];
	endfunction

endpackage

[hw/rtl/tmi_prog_store.sv]
// Program store: synchronous RAM with one write and one registered read port.
// Runs a clearing pass over every entry after reset. Depends on tmi_pkg.
module tmi_prog_store (
	input  logic               clk,
	input  logic               arst_n,
	input  tmi_pkg::prog_req_t req,
	output logic [7:0]         rdata,
	output logic               busy
);

	logic [7:0]                  mem [tmi_pkg::PROG_DEPTH];
	logic [tmi_pkg::PROG_AW-1:0] clr_q;
	logic                        busy_q;
	logic [7:0]                  rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == tmi_pkg::PROG_LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= 8'h00;
		end else if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rdata_q <= mem[req.rd_addr];
		end
	end

	assign rdata = rdata_q;
	assign busy  = busy_q;

endmodule

[hw/rtl/tmi_cell_store.sv]
// Cell store: synchronous RAM at the cell pointer, with a fill count.
// Cells at or above the fill count read as zero. Depends on tmi_pkg.
module tmi_cell_store (
	input  logic               clk,
	input  logic               arst_n,
	input  tmi_pkg::cell_req_t req,
	output tmi_pkg::cell_rd_t  rd
);

	logic [7:0]                mem [tmi_pkg::CELL_DEPTH];
	logic [tmi_pkg::CELL_AW:0] fill_q;
	logic [7:0]                rdata_q;
	logic                      init_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (req.wr_en && ({1'b0, req.addr} == fill_q)) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rdata_q <= mem[req.addr];
			init_q  <= {1'b0, req.addr} < fill_q;
		end
	end

	assign rd.init = init_q;
	assign rd.data = init_q ? rdata_q : 8'h00;

endmodule

[hw/rtl/tmi_ctrl.sv]
// Sequencer: accepts items, decodes one program character, scans for brackets
// and holds the result register. Drives both stores. Depends on tmi_pkg.
module tmi_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  tmi_pkg::req_t      req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output tmi_pkg::rsp_t      rsp,
	output tmi_pkg::prog_req_t prog,
	input  logic [7:0]         prog_rdata,
	input  logic               prog_busy,
	output tmi_pkg::cell_req_t cell_req,
	input  tmi_pkg::cell_rd_t  cell_rd
);

	tmi_pkg::state_t             state_q, state_d;
	tmi_pkg::req_t               req_q, req_d;
	tmi_pkg::halt_t              halt_q, halt_d, halt_n;
	logic [tmi_pkg::PROG_AW-1:0] ip_q, ip_d, ip_n, tgt, pos_q, pos_d, pos_n;
	logic [tmi_pkg::CELL_AW-1:0] cp_q, cp_d, cp_n;
	logic [tmi_pkg::DEPTH_W-1:0] depth_q, depth_d, depth_n;
	logic                        fwd_q, fwd_d;
	logic                        rsp_valid_q;
	tmi_pkg::rsp_t               rsp_q, res;
	logic                        slot_free, fin, adv, err, commit, hit;
	logic                        cwr_en;
	logic [7:0]                  cwr_data;

	assign slot_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tmi_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_d     = req_q;
		halt_n    = halt_q;
		ip_n      = ip_q;
		cp_n      = cp_q;
		tgt       = ip_q;
		pos_d     = pos_q;
		pos_n     = pos_q;
		depth_d   = depth_q;
		depth_n   = depth_q;
		fwd_d     = fwd_q;
		fin       = 1'b0;
		adv       = 1'b0;
		err       = 1'b0;
		hit       = 1'b0;
		cwr_en    = 1'b0;
		cwr_data  = 8'h00;
		req_stall = 1'b1;
		res       = '0;
		prog      = '0;
		cell_req  = '0;
		prog.rd_addr  = ip_q;
		cell_req.addr = cp_q;

		case (state_q)
			tmi_pkg::ST_IDLE: begin
				req_stall = prog_busy;
				if (req_valid && !prog_busy) begin
					req_d          = req;
					prog.rd_en     = 1'b1;
					cell_req.rd_en = 1'b1;
					prog.wr_addr   = tmi_pkg::prog_index(req.prog_addr);
					prog.wr_data   = req.prog_char;
					prog.wr_en     = (req.req_type == tmi_pkg::REQ_LOAD) &&
						tmi_pkg::prog_in_range(req.prog_addr);
					state_d        = tmi_pkg::ST_EXEC;
				end
			end
			tmi_pkg::ST_EXEC: begin
				if (req_q.req_type == tmi_pkg::REQ_LOAD || halt_q != tmi_pkg::HALT_RUN) begin
					fin = 1'b1;
				end else begin
					case (prog_rdata)
						tmi_pkg::CH_END: begin
							fin    = 1'b1;
							halt_n = tmi_pkg::HALT_DONE;
						end
						tmi_pkg::CH_RIGHT: begin
							fin = 1'b1;
							adv = 1'b1;
							if (cp_q != tmi_pkg::CELL_LAST) begin
								cp_n   = cp_q + 1'b1;
								cwr_en = !cell_rd.init;
							end
						end
						tmi_pkg::CH_LEFT: begin
							fin = 1'b1;
							adv = 1'b1;
							if (cp_q != '0) begin
								cp_n = cp_q - 1'b1;
							end
						end
						tmi_pkg::CH_INC: begin
							fin      = 1'b1;
							adv      = 1'b1;
							cwr_en   = 1'b1;
							cwr_data = cell_rd.data + 8'd1;
						end
						tmi_pkg::CH_DEC: begin
							fin      = 1'b1;
							adv      = 1'b1;
							cwr_en   = 1'b1;
							cwr_data = cell_rd.data - 8'd1;
						end
						tmi_pkg::CH_IN: begin
							fin          = 1'b1;
							adv          = 1'b1;
							cwr_en       = 1'b1;
							cwr_data     = req_q.in_byte;
							res.in_taken = 1'b1;
						end
						tmi_pkg::CH_OUT: begin
							fin           = 1'b1;
							adv           = 1'b1;
							res.out_valid = 1'b1;
							res.out_byte  = cell_rd.data;
						end
						tmi_pkg::CH_OPEN: begin
							if (cell_rd.data != 8'h00) begin
								fin = 1'b1;
								adv = 1'b1;
							end else if (ip_q == tmi_pkg::PROG_LAST) begin
								fin = 1'b1;
								err = 1'b1;
							end else begin
								pos_n        = ip_q + 1'b1;
								prog.rd_en   = 1'b1;
								prog.rd_addr = pos_n;
								pos_d        = pos_n;
								depth_d      = tmi_pkg::DEPTH_W'(1);
								fwd_d        = 1'b1;
								state_d      = tmi_pkg::ST_SCAN;
							end
						end
						tmi_pkg::CH_CLOSE: begin
							if (cell_rd.data == 8'h00) begin
								fin = 1'b1;
								adv = 1'b1;
							end else if (ip_q == '0) begin
								fin = 1'b1;
								err = 1'b1;
							end else begin
								pos_n        = ip_q - 1'b1;
								prog.rd_en   = 1'b1;
								prog.rd_addr = pos_n;
								pos_d        = pos_n;
								depth_d      = tmi_pkg::DEPTH_W'(1);
								fwd_d        = 1'b0;
								state_d      = tmi_pkg::ST_SCAN;
							end
						end
						default: begin
							fin = 1'b1;
							adv = 1'b1;
						end
					endcase
				end
			end
			tmi_pkg::ST_SCAN: begin
				if (fwd_q) begin
					if (prog_rdata == tmi_pkg::CH_END) begin
						err = 1'b1;
					end else if (prog_rdata == tmi_pkg::CH_OPEN) begin
						depth_n = depth_q + 1'b1;
					end else if (prog_rdata == tmi_pkg::CH_CLOSE) begin
						if (depth_q == tmi_pkg::DEPTH_W'(1)) begin
							hit = 1'b1;
						end else begin
							depth_n = depth_q - 1'b1;
						end
					end
				end else begin
					if (prog_rdata == tmi_pkg::CH_OPEN) begin
						if (depth_q == tmi_pkg::DEPTH_W'(1)) begin
							hit = 1'b1;
						end else begin
							depth_n = depth_q - 1'b1;
						end
					end else if (prog_rdata == tmi_pkg::CH_CLOSE) begin
						depth_n = depth_q + 1'b1;
					end
				end
				if (hit) begin
					fin = 1'b1;
					adv = 1'b1;
					tgt = pos_q;
				end else if (err) begin
					fin = 1'b1;
				end else if (fwd_q ? (pos_q == tmi_pkg::PROG_LAST) : (pos_q == '0)) begin
					fin = 1'b1;
					err = 1'b1;
				end else begin
					pos_n        = fwd_q ? pos_q + 1'b1 : pos_q - 1'b1;
					prog.rd_en   = 1'b1;
					prog.rd_addr = pos_n;
					pos_d        = pos_n;
					depth_d      = depth_n;
				end
			end
			default: begin
				state_d = tmi_pkg::ST_IDLE;
			end
		endcase

		if (err) begin
			halt_n = tmi_pkg::HALT_BRACKET;
		end else if (adv) begin
			if (tgt == tmi_pkg::PROG_LAST) begin
				ip_n   = tmi_pkg::PROG_LAST;
				halt_n = tmi_pkg::HALT_DONE;
			end else begin
				ip_n = tgt + 1'b1;
			end
		end

		res.run_status = (req_q.req_type == tmi_pkg::REQ_LOAD) ? tmi_pkg::HALT_RUN : halt_n;
		res.next_ip    = tmi_pkg::ip_field(ip_n);

		commit = fin && slot_free;
		halt_d = halt_q;
		ip_d   = ip_q;
		cp_d   = cp_q;
		if (commit) begin
			halt_d           = halt_n;
			ip_d             = ip_n;
			cp_d             = cp_n;
			cell_req.wr_en   = cwr_en;
			cell_req.wr_data = cwr_data;
			state_d          = tmi_pkg::ST_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halt_q      <= tmi_pkg::HALT_RUN;
			ip_q        <= '0;
			cp_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			halt_q <= halt_d;
			ip_q   <= ip_d;
			cp_q   <= cp_d;
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		req_q   <= req_d;
		pos_q   <= pos_d;
		depth_q <= depth_d;
		fwd_q   <= fwd_d;
		if (commit) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_scan_depth: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tmi_pkg::ST_SCAN |-> depth_q != '0)
		else $error("bracket scan running with zero depth");

	a_ip_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!commit |=> $stable(ip_q) && $stable(cp_q))
		else $error("pointer moved without a committed item");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q != tmi_pkg::HALT_RUN |=> halt_q == $past(halt_q))
		else $error("halt code left its halted value");

	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		prog_busy |-> state_q == tmi_pkg::ST_IDLE && !cell_req.wr_en)
		else $error("item in flight during program store clearing");

endmodule

[hw/rtl/tape_machine_interpreter_top.sv]
// Tape machine interpreter top level: program store, cell store and sequencer.
// Depends on tmi_pkg, tmi_prog_store, tmi_cell_store and tmi_ctrl.
//
// After reset the block clears the program store, one entry a cycle, and holds
// req_stall high until the clearing pass ends. Load items and non-jump step items
// first read the program and cell RAMs, then decode, write the cell back and load
// the result register once the result slot is free. A bracket that jumps adds a
// scan of the program for its match, which reads the program RAM one entry a
// cycle. The cell store needs no clearing pass: a fill count marks unwritten cells,
// which read as zero. Results leave through a register, so a new item is taken
// while the last result waits on rsp_stall.
module tape_machine_interpreter_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  tmi_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output tmi_pkg::rsp_t rsp
);

	tmi_pkg::prog_req_t prog;
	tmi_pkg::cell_req_t cell_req;
	tmi_pkg::cell_rd_t  cell_rd;
	logic [7:0]         prog_rdata;
	logic               prog_busy;

	tmi_prog_store u_prog (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (prog),
		.rdata  (prog_rdata),
		.busy   (prog_busy)
	);

	tmi_cell_store u_cell (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cell_req),
		.rd     (cell_rd)
	);

	tmi_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.prog       (prog),
		.prog_rdata (prog_rdata),
		.prog_busy  (prog_busy),
		.cell_req   (cell_req),
		.cell_rd    (cell_rd)
	);

endmodule

[test/tape_machine_interpreter_top_tb.sv]
// Self-checking bench for tape_machine_interpreter_top: loads programs, steps them and
// compares every result item against a scripted value or a predictor of the tape
// machine kept here. Depends on tmi_pkg and the RTL under hw/rtl.
`timescale 1ns / 1ps

module tape_machine_interpreter_top_tb;

	localparam int DIR_ROWS     = 24;
	localparam int RAND_ITEMS   = 1150;
	localparam int STEP_CAP     = 120;
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int LIMIT        = 1000000;

	localparam logic [7:0] CH_SKIP = 8'h20;

	localparam tmi_pkg::rsp_t LOAD_OK = '{1'b0, 8'h00, 1'b0, tmi_pkg::HALT_RUN, 12'd0};

	typedef struct packed {
		tmi_pkg::req_t rq;
		logic          typed;
		tmi_pkg::rsp_t want;
	} dir_row_t;

	typedef enum logic [1:0] {
		STOP_ZERO,
		STOP_OPEN,
		STOP_CLOSE
	} stop_kind_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_stall;
	tmi_pkg::req_t req = '0;
	logic          rsp_valid;
	logic          rsp_stall = 1'b0;
	tmi_pkg::rsp_t rsp;

	// machine state as predicted
	bit [7:0]                  prog_mem [tmi_pkg::PROG_DEPTH];
	bit [7:0]                  cell_mem [tmi_pkg::CELL_DEPTH];
	bit [tmi_pkg::PROG_AW-1:0] ip;
	bit [tmi_pkg::CELL_AW-1:0] cp;
	tmi_pkg::halt_t            halt = tmi_pkg::HALT_RUN;

	tmi_pkg::rsp_t pending_rsp [$];
	dir_row_t      script [DIR_ROWS];
	int            failures = 0;
	int            items_sent = 0;
	int            results_seen = 0;
	int            cycles = 0;
	int            gap_pct = 0;
	bit            calm = 1'b0;
	bit            held = 1'b0;

	tape_machine_interpreter_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int match_close(input int from);
		int p;
		int depth;
		p = from;
		depth = 1;
		while (p + 1 < tmi_pkg::PROG_DEPTH) begin
			p++;
			if (prog_mem[p] == tmi_pkg::CH_END)
				return -1;
			if (prog_mem[p] == tmi_pkg::CH_OPEN)
				depth++;
			else if (prog_mem[p] == tmi_pkg::CH_CLOSE) begin
				depth--;
				if (depth == 0)
					return p;
			end
		end
		return -1;
	endfunction

	function automatic int match_open(input int from);
		int p;
		int depth;
		p = from;
		depth = 1;
		while (p > 0) begin
			p--;
			if (prog_mem[p] == tmi_pkg::CH_OPEN) begin
				depth--;
				if (depth == 0)
					return p;
			end else if (prog_mem[p] == tmi_pkg::CH_CLOSE)
				depth++;
		end
		return -1;
	endfunction

	function automatic tmi_pkg::rsp_t machine_step(input tmi_pkg::req_t item);
		tmi_pkg::rsp_t o;
		int            tgt;
		bit            stuck;
		o = '0;
		if (item.req_type == tmi_pkg::REQ_LOAD) begin
			prog_mem[item.prog_addr] = item.prog_char;
			o.run_status = tmi_pkg::HALT_RUN;
			o.next_ip = ip;
			return o;
		end
		if (halt != tmi_pkg::HALT_RUN) begin
			o.run_status = halt;
			o.next_ip = ip;
			return o;
		end
		tgt = ip;
		stuck = 1'b0;
		case (prog_mem[ip])
			tmi_pkg::CH_END: begin
				halt = tmi_pkg::HALT_DONE;
				stuck = 1'b1;
			end
			tmi_pkg::CH_RIGHT: if (cp != tmi_pkg::CELL_LAST) cp++;
			tmi_pkg::CH_LEFT: if (cp != 0) cp--;
			tmi_pkg::CH_INC: cell_mem[cp] = cell_mem[cp] + 8'd1;
			tmi_pkg::CH_DEC: cell_mem[cp] = cell_mem[cp] - 8'd1;
			tmi_pkg::CH_IN: begin
				cell_mem[cp] = item.in_byte;
				o.in_taken = 1'b1;
			end
			tmi_pkg::CH_OUT: begin
				o.out_valid = 1'b1;
				o.out_byte = cell_mem[cp];
			end
			tmi_pkg::CH_OPEN: if (cell_mem[cp] == 8'd0) begin
				tgt = match_close(ip);
				stuck = tgt < 0;
			end
			tmi_pkg::CH_CLOSE: if (cell_mem[cp] != 8'd0) begin
				tgt = match_open(ip);
				stuck = tgt < 0;
			end
			default: ;
		endcase
		if (stuck && halt == tmi_pkg::HALT_RUN)
			halt = tmi_pkg::HALT_BRACKET;
		if (!stuck) begin
			if (tgt == tmi_pkg::PROG_DEPTH - 1) begin
				ip = tmi_pkg::PROG_LAST;
				halt = tmi_pkg::HALT_DONE;
			end else
				ip = tmi_pkg::PROG_AW'(tgt + 1);
		end
		o.run_status = halt;
		o.next_ip = ip;
		return o;
	endfunction

	function automatic logic [7:0] pick_cmd();
		logic [7:0] c;
		case ($urandom_range(0, 6))
			0: c = tmi_pkg::CH_INC;
			1: c = tmi_pkg::CH_DEC;
			2: c = tmi_pkg::CH_RIGHT;
			3: c = tmi_pkg::CH_LEFT;
			4: c = tmi_pkg::CH_IN;
			5: c = tmi_pkg::CH_OUT;
			default: begin
				c = 8'($urandom_range(1, 255));
				if (c == tmi_pkg::CH_OPEN || c == tmi_pkg::CH_CLOSE)
					c = CH_SKIP;
			end
		endcase
		return c;
	endfunction

	function automatic tmi_pkg::req_t mk_load(input logic [tmi_pkg::ADDR_W-1:0] addr,
		input logic [7:0] ch);
		return '{tmi_pkg::REQ_LOAD, addr, ch, 8'($urandom_range(0, 255))};
	endfunction

	function automatic tmi_pkg::req_t mk_step(input logic [7:0] inb);
		return '{tmi_pkg::REQ_STEP, 12'($urandom_range(0, 4095)),
			8'($urandom_range(0, 255)), inb};
	endfunction

	task automatic issue(input tmi_pkg::req_t item, input logic typed = 1'b0,
		input tmi_pkg::rsp_t want = '0);
		tmi_pkg::rsp_t model_out;
		@(negedge clk);
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		model_out = machine_step(item);
		pending_rsp.push_back(typed ? want : model_out);
		items_sent++;
		if (!calm && $urandom_range(0, 99) < gap_pct)
			repeat ($urandom_range(1, 7)) begin
				@(negedge clk);
				req_valid <= 1'b0;
			end
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			failures++;
		end
	endtask

	always @(posedge clk) begin : result_check
		tmi_pkg::rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			results_seen++;
			if (pending_rsp.size() == 0) begin
				$error("result item with nothing pending: 0x%0h", rsp);
				failures++;
			end else begin
				want = pending_rsp.pop_front();
				check_field("out_valid", want.out_valid, rsp.out_valid);
				check_field("out_byte", want.out_byte, rsp.out_byte);
				check_field("in_taken", want.in_taken, rsp.in_taken);
				check_field("run_status", want.run_status, rsp.run_status);
				check_field("next_ip", want.next_ip, rsp.next_ip);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: short random stall bursts, quiet stretches, one long hold
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && results_seen >= 300) begin
				held = 1'b1;
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else if (!calm && (results_seen / 64) % 3 != 0 && $urandom_range(0, 99) < 15) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(0, 6)) @(negedge clk);
			end else
				rsp_stall <= 1'b0;
		end
	end

	initial begin
		logic [7:0] seg [$];
		int         seg_len;
		int         open_cnt;
		int         base;
		int         steps;
		int         k;
		logic [7:0] inb;
		stop_kind_t stop;

		script = '{
			'{'{tmi_pkg::REQ_LOAD, 12'd0, tmi_pkg::CH_LEFT, 8'h00}, 1'b1, LOAD_OK},
			'{'{tmi_pkg::REQ_LOAD, 12'd1, tmi_pkg::CH_DEC, 8'h00}, 1'b1, LOAD_OK},
			'{'{tmi_pkg::REQ_LOAD, 12'd2, tmi_pkg::CH_OUT, 8'h00}, 1'b1, LOAD_OK},
			'{'{tmi_pkg::REQ_LOAD, 12'd3, tmi_pkg::CH_INC, 8'h00}, 1'b1, LOAD_OK},
			'{'{tmi_pkg::REQ_LOAD, 12'd4, tmi_pkg::CH_IN, 8'h00}, 1'b1, LOAD_OK},
			'{'{tmi_pkg::REQ_LOAD, 12'd5, tmi_pkg::CH_OPEN, 8'h00}, 1'b1, LOAD_OK},
			'{'{tmi_pkg::REQ_LOAD, 12'd6, tmi_pkg::CH_DEC, 8'h00}, 1'b1, LOAD_OK},
			'{'{tmi_pkg::REQ_LOAD, 12'd7, tmi_pkg::CH_CLOSE, 8'h00}, 1'b1, LOAD_OK},
			'{'{tmi_pkg::REQ_LOAD, 12'd8, tmi_pkg::CH_OPEN, 8'h00}, 1'b1, LOAD_OK},
			'{'{tmi_pkg::REQ_LOAD, 12'd9, tmi_pkg::CH_CLOSE, 8'h00}, 1'b1, LOAD_OK},
			'{'{tmi_pkg::REQ_LOAD, 12'd10, 8'hFF, 8'hFF}, 1'b1, LOAD_OK},
			'{'{tmi_pkg::REQ_LOAD, 12'hFFF, 8'hFF, 8'hFF}, 1'b1, LOAD_OK},
			'{'{tmi_pkg::REQ_STEP, 12'hFFF, 8'hFF, 8'h00}, 1'b1,
				'{1'b0, 8'h00, 1'b0, tmi_pkg::HALT_RUN, 12'd1}},
			'{'{tmi_pkg::REQ_STEP, 12'h000, 8'h00, 8'hFF}, 1'b1,
				'{1'b0, 8'h00, 1'b0, tmi_pkg::HALT_RUN, 12'd2}},
			'{'{tmi_pkg::REQ_STEP, 12'hABC, 8'h5A, 8'h00}, 1'b1,
				'{1'b1, 8'hFF, 1'b0, tmi_pkg::HALT_RUN, 12'd3}},
			'{'{tmi_pkg::REQ_STEP, 12'h543, 8'hA5, 8'h00}, 1'b1,
				'{1'b0, 8'h00, 1'b0, tmi_pkg::HALT_RUN, 12'd4}},
			'{'{tmi_pkg::REQ_STEP, 12'h000, 8'h00, 8'h02}, 1'b1,
				'{1'b0, 8'h00, 1'b1, tmi_pkg::HALT_RUN, 12'd5}},
			'{'{tmi_pkg::REQ_STEP, 12'h000, 8'h00, 8'h00}, 1'b0, '0},
			'{'{tmi_pkg::REQ_STEP, 12'h000, 8'h00, 8'h00}, 1'b0, '0},
			'{'{tmi_pkg::REQ_STEP, 12'h000, 8'h00, 8'h00}, 1'b0, '0},
			'{'{tmi_pkg::REQ_STEP, 12'h000, 8'h00, 8'h00}, 1'b0, '0},
			'{'{tmi_pkg::REQ_STEP, 12'h000, 8'h00, 8'h00}, 1'b0, '0},
			'{'{tmi_pkg::REQ_STEP, 12'h000, 8'h00, 8'h00}, 1'b0, '0},
			'{'{tmi_pkg::REQ_STEP, 12'hFFF, 8'hFF, 8'hFF}, 1'b0, '0}
		};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i])
			issue(script[i].rq, script[i].typed, script[i].want);

		// well-formed segments with random content, loaded at ip and then run
		while (items_sent < DIR_ROWS + RAND_ITEMS) begin
			gap_pct = $urandom_range(0, 1) ? 30 : 0;
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3))
					issue(mk_load(12'($urandom_range(int'(ip) + 32, tmi_pkg::PROG_DEPTH - 1)),
						8'($urandom_range(0, 255))));
			seg_len = $urandom_range(1, 16);
			open_cnt = 0;
			seg.delete();
			repeat (seg_len) begin
				k = $urandom_range(0, 99);
				if (k < 12 && open_cnt < 3) begin
					seg.push_back(tmi_pkg::CH_OPEN);
					open_cnt++;
				end else if (k < 24 && open_cnt > 0) begin
					seg.push_back(tmi_pkg::CH_CLOSE);
					open_cnt--;
				end else
					seg.push_back(pick_cmd());
			end
			repeat (open_cnt) seg.push_back(tmi_pkg::CH_CLOSE);
			base = ip;
			foreach (seg[i])
				issue(mk_load(12'(base + i), seg[i]));
			steps = 0;
			while (int'(ip) < base + seg.size()) begin
				// break a loop that runs too long: flatten every bracket in the segment
				if (steps == STEP_CAP)
					foreach (seg[i])
						if (seg[i] == tmi_pkg::CH_OPEN || seg[i] == tmi_pkg::CH_CLOSE)
							issue(mk_load(12'(base + i), CH_SKIP));
				inb = $urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom_range(0, 255));
				issue(mk_step(inb));
				steps++;
			end
		end

		// end the program one way, then poke the halted machine
		calm = 1'b1;
		stop = stop_kind_t'($urandom_range(0, 2));
		base = ip;
		case (stop)
			STOP_ZERO: issue(mk_load(12'(base), tmi_pkg::CH_END));
			STOP_OPEN: begin
				issue(mk_load(12'(base), tmi_pkg::CH_IN));
				issue(mk_load(12'(base + 1), tmi_pkg::CH_OPEN));
				seg_len = $urandom_range(0, 5);
				for (k = 0; k < seg_len; k++)
					issue(mk_load(12'(base + 2 + k), pick_cmd()));
				issue(mk_load(12'(base + 2 + seg_len), tmi_pkg::CH_END));
			end
			default: begin
				issue(mk_load(12'(base), tmi_pkg::CH_IN));
				issue(mk_load(12'(base + 1), tmi_pkg::CH_CLOSE));
			end
		endcase
		while (halt == tmi_pkg::HALT_RUN)
			issue(mk_step(stop == STOP_CLOSE ? 8'($urandom_range(1, 255)) : 8'h00));
		repeat (6)
			if ($urandom_range(0, 1))
				issue(mk_step(8'($urandom_range(0, 255))));
			else
				issue(mk_load(12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255))));

		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/tmi_pkg.sv
hw/rtl/tmi_prog_store.sv
hw/rtl/tmi_cell_store.sv
hw/rtl/tmi_ctrl.sv
hw/rtl/tape_machine_interpreter_top.sv
test/tape_machine_interpreter_top_tb.sv
